>>> rtl/nsrr_pkg.sv
`timescale 1ns / 1ps

package nsrr_pkg;

    localparam int MAX_NODES_DEF = 32;
    localparam int NODE_W        = 5;
    localparam int STATUS_W      = 2;
    localparam int ACT_W         = 2;
    localparam int MASK_W        = 32;
    localparam int CFG_IDX_W     = 1;

    typedef logic [NODE_W-1:0]   t_node;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [ACT_W-1:0]    t_action;

    localparam t_status ST_FREE     = 2'd0;
    localparam t_status ST_LOW      = 2'd1;
    localparam t_status ST_OUT      = 2'd2;
    localparam t_status ST_RESERVED = 2'd3;

    localparam t_action ACT_NONE    = 2'd0;
    localparam t_action ACT_ENABLE  = 2'd1;
    localparam t_action ACT_DISABLE = 2'd2;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_PICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_MASK = 1'd1;

endpackage

>>> rtl/node_status_round_robin_picker.sv
`timescale 1ns / 1ps

// node status round-robin picker
// input channel (i_valid / o_ready) carries one command beat: an update writes
// the memory-pressure status of one node, a pick searches the online ring for
// a target node. every beat yields exactly one result beat on the output
// channel (o_valid / i_ready).
// the configuration channel (i_cfg_valid / o_cfg_ready) is always ready;
// index 0 sets the own node id, index 1 sets the online mask. write it idle.
// an update goes from the input registers through the busy and finish states
// to the output register. a pick walks the ring one node per cycle through a
// single position counter and one status compare, first pass free nodes only,
// second pass free or low nodes, then loads the output register.
// one item is in work at a time; o_ready is high only when idle. a finished
// result waits in the output register while the receiver stalls, and the
// next item is accepted meanwhile but completes only after that beat drains.
// synchronous reset clears the status table to free, forgets the last pick,
// sets own node 0 and online mask 1; no output beat is pending after reset.
module node_status_round_robin_picker #(
    parameter int MAX_NODES = nsrr_pkg::MAX_NODES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_command,
    input  nsrr_pkg::t_node                      i_node,
    input  nsrr_pkg::t_status                    i_status,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output nsrr_pkg::t_node                      o_chosen_node,
    output logic                                 o_chosen_valid,
    output nsrr_pkg::t_action                    o_lowmem_action,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [nsrr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nsrr_pkg::MASK_W-1:0]          i_cfg_data
);

    localparam int NE = (MAX_NODES >= nsrr_pkg::MASK_W) ? nsrr_pkg::MASK_W : MAX_NODES;
    localparam int AW = $clog2(NE);
    localparam logic [nsrr_pkg::NODE_W:0] NE_L = (nsrr_pkg::NODE_W + 1)'(NE);
    localparam logic [nsrr_pkg::MASK_W-1:0] LIVE_KEEP =
        (NE >= nsrr_pkg::MASK_W) ? {nsrr_pkg::MASK_W{1'b1}}
                                 : nsrr_pkg::MASK_W'((64'd1 << NE) - 64'd1);
    localparam nsrr_pkg::t_node LAST_STEP = {nsrr_pkg::NODE_W{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_FINISH
    } t_state;

    t_state                          r_state;
    nsrr_pkg::t_node                 r_own;
    logic [nsrr_pkg::MASK_W-1:0]     r_online;
    nsrr_pkg::t_node                 r_last;
    logic                            r_last_valid;
    logic                            r_cmd;
    nsrr_pkg::t_node                 r_node;
    nsrr_pkg::t_status               r_status;
    nsrr_pkg::t_node                 r_step;
    logic                            r_pass;
    nsrr_pkg::t_node                 r_res_node;
    logic                            r_res_valid;
    nsrr_pkg::t_action               r_res_act;
    logic                            r_o_valid;
    nsrr_pkg::t_node                 r_o_node;
    logic                            r_o_chosen;
    nsrr_pkg::t_action               r_o_act;

    logic [nsrr_pkg::MASK_W-1:0]     w_live;
    logic                            w_multi;
    nsrr_pkg::t_node                 w_start;
    nsrr_pkg::t_node                 w_pos;
    logic                            w_node_ok;
    logic [AW-1:0]                   w_raddr;
    nsrr_pkg::t_status               w_rdata;
    logic                            w_we;
    logic                            w_hit;
    nsrr_pkg::t_action               w_act;

    assign w_live    = r_online & LIVE_KEEP;
    assign w_multi   = |(w_live & (w_live - nsrr_pkg::MASK_W'(1)));
    assign w_start   = r_last_valid ? r_last : r_own;
    assign w_pos     = w_start + nsrr_pkg::NODE_W'(1) + r_step;
    assign w_node_ok = {1'b0, r_node} < NE_L;
    assign w_raddr   = (r_cmd == nsrr_pkg::CMD_PICK) ? w_pos[AW-1:0] : r_node[AW-1:0];
    assign w_we      = (r_state == S_BUSY) && (r_cmd == nsrr_pkg::CMD_UPDATE) && w_node_ok;

    nsrr_table #(
        .DEPTH (NE),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (r_node[AW-1:0]),
        .i_wdata (r_status),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared compare: live, not own, status acceptable for this pass
    assign w_hit = w_live[w_pos] && (w_pos != r_own) &&
                   ((w_rdata == nsrr_pkg::ST_FREE) ||
                    (r_pass && (w_rdata == nsrr_pkg::ST_LOW)));

    always_comb begin
        if (!w_node_ok) begin
            w_act = nsrr_pkg::ACT_NONE;
        end else if (r_status == nsrr_pkg::ST_OUT) begin
            w_act = nsrr_pkg::ACT_ENABLE;
        end else if (w_rdata == nsrr_pkg::ST_OUT) begin
            w_act = nsrr_pkg::ACT_DISABLE;
        end else begin
            w_act = nsrr_pkg::ACT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_own        <= '0;
            r_online     <= nsrr_pkg::MASK_W'(1);
            r_last       <= '0;
            r_last_valid <= 1'b0;
            r_o_valid    <= 1'b0;
            r_step       <= '0;
            r_pass       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    nsrr_pkg::CFG_OWN_NODE:    r_own    <= i_cfg_data[nsrr_pkg::NODE_W-1:0];
                    nsrr_pkg::CFG_ONLINE_MASK: r_online <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_o_valid && i_ready && (r_state != S_FINISH)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= i_command;
                        r_node   <= i_node;
                        r_status <= i_status;
                        r_step   <= '0;
                        r_pass   <= 1'b0;
                        r_state  <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (r_cmd == nsrr_pkg::CMD_UPDATE) begin
                        r_res_node  <= '0;
                        r_res_valid <= 1'b0;
                        r_res_act   <= w_act;
                        r_state     <= S_FINISH;
                    end else if (!w_multi) begin
                        r_res_node  <= '0;
                        r_res_valid <= 1'b0;
                        r_res_act   <= nsrr_pkg::ACT_NONE;
                        r_state     <= S_FINISH;
                    end else if (w_hit) begin
                        r_res_node   <= w_pos;
                        r_res_valid  <= 1'b1;
                        r_res_act    <= nsrr_pkg::ACT_NONE;
                        r_last       <= w_pos;
                        r_last_valid <= 1'b1;
                        r_state      <= S_FINISH;
                    end else if (r_step == LAST_STEP) begin
                        r_step <= '0;
                        if (r_pass) begin
                            r_res_node  <= '0;
                            r_res_valid <= 1'b0;
                            r_res_act   <= nsrr_pkg::ACT_NONE;
                            r_state     <= S_FINISH;
                        end else begin
                            r_pass <= 1'b1;
                        end
                    end else begin
                        r_step <= r_step + nsrr_pkg::NODE_W'(1);
                    end
                end
                S_FINISH: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_node   <= r_res_node;
                        r_o_chosen <= r_res_valid;
                        r_o_act    <= r_res_act;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_chosen_node   = r_o_node;
    assign o_chosen_valid  = r_o_chosen;
    assign o_lowmem_action = r_o_act;
    assign o_cfg_ready     = 1'b1;

endmodule

>>> rtl/nsrr_table.sv
`timescale 1ns / 1ps

module nsrr_table #(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  nsrr_pkg::t_status      i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output nsrr_pkg::t_status      o_rdata
);

    nsrr_pkg::t_status r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_mem[i] <= nsrr_pkg::ST_FREE;
            end
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[i_raddr];

endmodule

>>> test/picker_checker.sv
`timescale 1ns / 1ps

module picker_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_command,
    input  nsrr_pkg::t_node                i_node,
    input  nsrr_pkg::t_status              i_status,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  nsrr_pkg::t_node                i_chosen_node,
    input  logic                           i_chosen_valid,
    input  nsrr_pkg::t_action              i_lowmem_action,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [nsrr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nsrr_pkg::MASK_W-1:0]    i_cfg_data,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_picks_found,
    output int                             o_mode_changes
);

    typedef struct packed {
        nsrr_pkg::t_node   node;
        logic              found;
        nsrr_pkg::t_action action;
    } t_outcome;

    nsrr_pkg::t_status           node_state [32];
    nsrr_pkg::t_node             prev_pick;
    logic                        prev_pick_ok;
    nsrr_pkg::t_node             self_id;
    logic [nsrr_pkg::MASK_W-1:0] ring;
    t_outcome                    pending_outcomes [$];
    int                          error_count;
    int                          found_count;
    int                          mode_count;

    // next online node strictly after pos, wrapping round the ring
    function automatic nsrr_pkg::t_node ring_after(nsrr_pkg::t_node pos);
        nsrr_pkg::t_node idx;
        int              k;
        idx = pos;
        for (k = 0; k < 32; k++) begin
            idx = idx + nsrr_pkg::NODE_W'(1);
            if (ring[idx]) begin
                return idx;
            end
        end
        return pos;
    endfunction

    function automatic t_outcome predict_outcome(logic cmd, nsrr_pkg::t_node n,
                                                 nsrr_pkg::t_status s);
        t_outcome          r;
        nsrr_pkg::t_status old;
        nsrr_pkg::t_node   cur;
        nsrr_pkg::t_node   start;
        int                online;
        int                pass;
        int                k;
        r = '0;
        if (cmd == nsrr_pkg::CMD_UPDATE) begin
            old = node_state[n];
            node_state[n] = s;
            if (s == nsrr_pkg::ST_OUT) begin
                r.action = nsrr_pkg::ACT_ENABLE;
            end else if (old == nsrr_pkg::ST_OUT) begin
                r.action = nsrr_pkg::ACT_DISABLE;
            end
            return r;
        end
        online = $countones(ring);
        if (online < 2) begin
            return r;
        end
        start = prev_pick_ok ? prev_pick : self_id;
        for (pass = 0; pass < 2; pass++) begin
            cur = start;
            for (k = 0; k < online; k++) begin
                cur = ring_after(cur);
                if (cur != self_id && (node_state[cur] == nsrr_pkg::ST_FREE ||
                        (pass == 1 && node_state[cur] == nsrr_pkg::ST_LOW))) begin
                    prev_pick    = cur;
                    prev_pick_ok = 1'b1;
                    r.node       = cur;
                    r.found      = 1'b1;
                    return r;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int n = 0; n < 32; n++) begin
                node_state[n] = nsrr_pkg::ST_FREE;
            end
            prev_pick    = '0;
            prev_pick_ok = 1'b0;
            self_id      = '0;
            ring         = 32'd1;
            pending_outcomes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result beat with nothing outstanding: node %0d valid %0d action %0d",
                           i_chosen_node, i_chosen_valid, i_lowmem_action);
                    error_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (i_chosen_node !== want.node) begin
                        $error("chosen_node mismatch: expected %0d, actual %0d",
                               want.node, i_chosen_node);
                        error_count++;
                    end
                    if (i_chosen_valid !== want.found) begin
                        $error("chosen_valid mismatch: expected %0d, actual %0d",
                               want.found, i_chosen_valid);
                        error_count++;
                    end
                    if (i_lowmem_action !== want.action) begin
                        $error("lowmem_action mismatch: expected %0d, actual %0d",
                               want.action, i_lowmem_action);
                        error_count++;
                    end
                    if (want.found) begin
                        found_count++;
                    end
                    if (want.action != nsrr_pkg::ACT_NONE) begin
                        mode_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    nsrr_pkg::CFG_OWN_NODE: begin
                        self_id = i_cfg_data[nsrr_pkg::NODE_W-1:0];
                    end
                    nsrr_pkg::CFG_ONLINE_MASK: begin
                        ring = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                pending_outcomes.push_back(predict_outcome(i_command, i_node, i_status));
            end
        end
        o_errors       <= error_count;
        o_pending      <= pending_outcomes.size();
        o_picks_found  <= found_count;
        o_mode_changes <= mode_count;
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 152;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 18;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic                           i_command;
    nsrr_pkg::t_node                i_node;
    nsrr_pkg::t_status              i_status;
    logic                           o_valid;
    logic                           i_ready;
    nsrr_pkg::t_node                o_chosen_node;
    logic                           o_chosen_valid;
    nsrr_pkg::t_action              o_lowmem_action;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [nsrr_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [nsrr_pkg::MASK_W-1:0]    i_cfg_data;

    int   errors;
    int   pending;
    int   picks_found;
    int   mode_changes;
    int   cycles = 0;
    int   n_updates = 0;
    int   n_picks = 0;
    int   n_cfg = 0;
    int   hold_left;
    logic calm;
    logic pressure_req;
    logic pressure_done;

    node_status_round_robin_picker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_node          (i_node),
        .i_status        (i_status),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_chosen_node   (o_chosen_node),
        .o_chosen_valid  (o_chosen_valid),
        .o_lowmem_action (o_lowmem_action),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    picker_checker result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_command       (i_command),
        .i_node          (i_node),
        .i_status        (i_status),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_chosen_node   (o_chosen_node),
        .i_chosen_valid  (o_chosen_valid),
        .i_lowmem_action (o_lowmem_action),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_picks_found   (picks_found),
        .o_mode_changes  (mode_changes)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result receiver, with one long hold-off so the block backs up
    initial begin
        i_ready       <= 1'b0;
        hold_left     = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_req && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (calm) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // all tasks start and end right after a rising edge
    task automatic send_beat(input logic cmd, input nsrr_pkg::t_node n,
                             input nsrr_pkg::t_status s);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_node    <= n;
        i_status  <= s;
        do @(posedge i_clk); while (!o_ready);
        if (cmd == nsrr_pkg::CMD_PICK) begin
            n_picks++;
        end else begin
            n_updates++;
        end
    endtask

    task automatic pick_beat();
        send_beat(nsrr_pkg::CMD_PICK, nsrr_pkg::t_node'($urandom),
                  nsrr_pkg::t_status'($urandom));
    endtask

    task automatic cfg_write(input logic [nsrr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nsrr_pkg::MASK_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg++;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic nsrr_pkg::t_status pick_status();
        int r;
        r = $urandom_range(9);
        if (r < 5) begin
            return nsrr_pkg::ST_FREE;
        end else if (r < 7) begin
            return nsrr_pkg::ST_LOW;
        end else if (r < 9) begin
            return nsrr_pkg::ST_OUT;
        end
        return nsrr_pkg::ST_RESERVED;
    endfunction

    function automatic logic [nsrr_pkg::MASK_W-1:0] pick_mask();
        case ($urandom_range(5))
            0: return '1;
            1: return $urandom;
            2: return $urandom & $urandom & $urandom;
            3: return (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31));
            4: return 32'd1 << $urandom_range(31);
            default: return ~(32'd1 << $urandom_range(31));
        endcase
    endfunction

    initial begin
        logic [nsrr_pkg::MASK_W-1:0] mask;
        nsrr_pkg::t_node             own;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_command    <= nsrr_pkg::CMD_UPDATE;
        i_node       <= '0;
        i_status     <= nsrr_pkg::ST_FREE;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= nsrr_pkg::CFG_OWN_NODE;
        i_cfg_data   <= '0;
        calm         <= 1'b0;
        pressure_req <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: only one node online
        pick_beat();
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd31, nsrr_pkg::ST_OUT);
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd31, nsrr_pkg::ST_RESERVED);
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd31, nsrr_pkg::ST_RESERVED);
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd0, nsrr_pkg::ST_LOW);
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd0, nsrr_pkg::ST_FREE);
        settle();

        // full ring, first pick starts after own node, low and code three skipped
        cfg_write(nsrr_pkg::CFG_OWN_NODE, 32'd5);
        cfg_write(nsrr_pkg::CFG_ONLINE_MASK, 32'hFFFF_FFFF);
        pick_beat();
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd7, nsrr_pkg::ST_LOW);
        pick_beat();
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd9, nsrr_pkg::ST_RESERVED);
        pick_beat();
        settle();

        // last pick gone offline, second pass takes low, then a failed pick
        cfg_write(nsrr_pkg::CFG_ONLINE_MASK, 32'h8000_0021);
        pick_beat();
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd0, nsrr_pkg::ST_OUT);
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd31, nsrr_pkg::ST_LOW);
        pick_beat();
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd31, nsrr_pkg::ST_OUT);
        pick_beat();
        settle();

        cfg_write(nsrr_pkg::CFG_ONLINE_MASK, 32'd0);
        pick_beat();
        settle();

        // own node offline, picks wrap round the ring
        cfg_write(nsrr_pkg::CFG_OWN_NODE, 32'd31);
        cfg_write(nsrr_pkg::CFG_ONLINE_MASK, 32'h0000_0006);
        pick_beat();
        pick_beat();
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd1, nsrr_pkg::ST_LOW);
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd2, nsrr_pkg::ST_LOW);
        pick_beat();
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd0, nsrr_pkg::ST_FREE);
        send_beat(nsrr_pkg::CMD_UPDATE, 5'd31, nsrr_pkg::ST_FREE);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 1) begin
                own  = '0;
                mask = '1;
            end else if (ph == 2) begin
                own  = '1;
                mask = 32'h8000_0001;
            end else if (ph == 4) begin
                own  = nsrr_pkg::t_node'($urandom);
                mask = '0;
            end else begin
                own  = nsrr_pkg::t_node'($urandom);
                mask = pick_mask();
            end
            cfg_write(nsrr_pkg::CFG_OWN_NODE, {27'($urandom), own});
            cfg_write(nsrr_pkg::CFG_ONLINE_MASK, mask);
            calm <= (ph == 6);
            if (ph == 3) begin
                pressure_req <= 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(1)) begin
                    pick_beat();
                end else begin
                    send_beat(nsrr_pkg::CMD_UPDATE, nsrr_pkg::t_node'($urandom),
                              pick_status());
                end
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("ran %0d updates and %0d picks across %0d register writes",
                 n_updates, n_picks, n_cfg);
        $display("%0d picks found a target, %0d updates changed low-memory mode",
                 picks_found, mode_changes);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
